[rtl/core/assert_macros.svh]
// Assertion macros used by the checker module of the RTL.
// No dependencies; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dpr_pkg.sv]
// Shared types, character codes and helpers of the debug packet receiver.
// No dependencies; used by every module of the block but dpr_checker.
package dpr_pkg;

    localparam int BUF_DEPTH_DEF = 1024;
    localparam int IDX_W         = 10;
    localparam int LEN_W         = 10;

    // Framing and reply characters.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] DIGIT_BAD = 8'hFF;

    // Parser phases.
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;
    localparam logic [1:0] PH_LOW  = 2'd3;

    // Kinds of reply job handed to the transmit side.
    localparam logic [1:0] JOB_READ   = 2'd0;
    localparam logic [1:0] JOB_NACK   = 2'd1;
    localparam logic [1:0] JOB_ACK    = 2'd2;
    localparam logic [1:0] JOB_ACKSEQ = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [1:0]       kind;
        logic [LEN_W-1:0] len;
        logic [7:0]       seq0;
        logic [7:0]       seq1;
    } t_job;

    typedef struct packed {
        logic             tx_valid;
        logic [7:0]       tx_byte;
        logic             packet_ready;
        logic [1:0]       payload_start;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       read_data;
        logic             last;
    } t_res;

    // Hex digit value; anything else counts as all ones.
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = DIGIT_BAD;
        if (c inside {[CH_LA:CH_LF]}) begin
            v = c - CH_LA + 8'd10;
        end else if (c inside {[CH_ZERO:CH_NINE]}) begin
            v = c - CH_ZERO;
        end else if (c inside {[CH_UA:CH_UF]}) begin
            v = c - CH_UA + 8'd10;
        end
        return v;
    endfunction

endpackage

[rtl/core/dpr_buf.sv]
// Payload buffer: one write port for body bytes, one registered read port.
// Depends on dpr_pkg.
module dpr_buf #(
    parameter int BUF_DEPTH = dpr_pkg::BUF_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(BUF_DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]                   i_wr_data,
    input  logic                         i_rd_en,
    input  logic [dpr_pkg::IDX_W-1:0]    i_rd_index,
    output logic [7:0]                   o_rd_data
);
    import dpr_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;

    logic [7:0]    mem [BUF_DEPTH];
    logic [7:0]    r_rd_data;
    logic          r_rd_ok;
    logic [XW-1:0] idx_x;
    logic          rd_ok;

    assign idx_x = XW'(i_rd_index);
    assign rd_ok = 32'(i_rd_index) < 32'(BUF_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[idx_x[AW-1:0]];
            r_rd_ok   <= rd_ok;
        end
    end

    // Positions beyond the buffer read as zero.
    assign o_rd_data = r_rd_ok ? r_rd_data : 8'h00;

endmodule

[rtl/core/dpr_parse.sv]
// Packet framing parser: phase, running sum, checksum digits, body count.
// Depends on dpr_pkg; drives the write port of dpr_buf and issues reply jobs.
module dpr_parse #(
    parameter int BUF_DEPTH = dpr_pkg::BUF_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_action,
    input  logic [7:0]                   i_line_byte,
    output logic                         o_wr_en,
    output logic [$clog2(BUF_DEPTH)-1:0] o_wr_addr,
    output logic [7:0]                   o_wr_data,
    output dpr_pkg::t_job                o_job
);
    import dpr_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);
    localparam logic [AW-1:0] LIMIT = AW'(BUF_DEPTH - 2);

    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_sum, n_sum;
    logic [7:0]    r_high, n_high;
    logic [AW-1:0] r_count, n_count;
    logic [7:0]    r_b0, r_b1, r_b2;
    logic [7:0]    digit;
    logic [7:0]    sent;

    assign digit     = digit_value(i_line_byte);
    assign sent      = r_high + digit;
    assign o_wr_addr = r_count;
    assign o_wr_data = i_line_byte;

    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_high  = r_high;
        n_count = r_count;
        o_wr_en = 1'b0;
        o_job   = '0;
        if (i_accept && i_action) begin
            o_job.valid = 1'b1;
            o_job.kind  = JOB_READ;
        end else if (i_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_line_byte == CH_DOLLAR) begin
                        n_phase = PH_BODY;
                        n_sum   = 8'h00;
                        n_count = '0;
                    end
                end
                PH_BODY: begin
                    if (i_line_byte == CH_DOLLAR) begin
                        n_sum   = 8'h00;
                        n_count = '0;
                    end else if (i_line_byte == CH_HASH) begin
                        n_phase = PH_HIGH;
                    end else begin
                        n_sum   = r_sum + i_line_byte;
                        n_count = r_count + AW'(1);
                        o_wr_en = 1'b1;
                        // Body reaching BUF_DEPTH - 1 bytes: drop it quietly.
                        if (r_count == LIMIT) begin
                            n_phase = PH_HUNT;
                        end
                    end
                end
                PH_HIGH: begin
                    n_high  = {digit[3:0], 4'h0};
                    n_phase = PH_LOW;
                end
                default: begin
                    n_phase     = PH_HUNT;
                    o_job.valid = 1'b1;
                    o_job.len   = LEN_W'(r_count);
                    o_job.seq0  = r_b0;
                    o_job.seq1  = r_b1;
                    if (sent != r_sum) begin
                        o_job.kind = JOB_NACK;
                    end else if (r_count >= AW'(3) && r_b2 == CH_COLON) begin
                        o_job.kind = JOB_ACKSEQ;
                    end else begin
                        o_job.kind = JOB_ACK;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_sum   <= 8'h00;
            r_high  <= 8'h00;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_high  <= n_high;
            r_count <= n_count;
        end
    end

    // Copies of the first three body bytes, for the sequence id check.
    always_ff @(posedge i_clk) begin
        if (o_wr_en && r_count == AW'(0)) begin
            r_b0 <= i_line_byte;
        end
        if (o_wr_en && r_count == AW'(1)) begin
            r_b1 <= i_line_byte;
        end
        if (o_wr_en && r_count == AW'(2)) begin
            r_b2 <= i_line_byte;
        end
    end

endmodule

[rtl/core/dpr_tx.sv]
// Reply sequencer: holds one job, emits one to three results into an
// output register. Depends on dpr_pkg; takes read data from dpr_buf.
module dpr_tx (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dpr_pkg::t_job i_job,
    input  logic [7:0]    i_rd_data,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output dpr_pkg::t_res o_res
);
    import dpr_pkg::*;

    logic       r_job_valid;
    t_job       r_job;
    logic [1:0] r_step;
    logic       r_out_valid;
    t_res       r_res;
    t_res       res_c;
    logic [1:0] last_step;
    logic       load;
    logic       done;

    assign last_step = (r_job.kind == JOB_ACKSEQ) ? 2'd2 : 2'd0;
    assign load      = r_job_valid && (!r_out_valid || i_out_ready);
    assign done      = load && (r_step == last_step);
    assign o_in_ready = !r_job_valid || done;

    always_comb begin
        res_c = '0;
        case (r_job.kind)
            JOB_READ: begin
                res_c.read_data = i_rd_data;
                res_c.last      = 1'b1;
            end
            JOB_NACK: begin
                res_c.tx_valid = 1'b1;
                res_c.tx_byte  = CH_MINUS;
                res_c.last     = 1'b1;
            end
            JOB_ACK: begin
                res_c.tx_valid       = 1'b1;
                res_c.tx_byte        = CH_PLUS;
                res_c.packet_ready   = 1'b1;
                res_c.payload_length = r_job.len;
                res_c.last           = 1'b1;
            end
            default: begin
                res_c.tx_valid = 1'b1;
                if (r_step == 2'd0) begin
                    res_c.tx_byte = CH_PLUS;
                end else if (r_step == 2'd1) begin
                    res_c.tx_byte = r_job.seq0;
                end else begin
                    res_c.tx_byte        = r_job.seq1;
                    res_c.packet_ready   = 1'b1;
                    res_c.payload_start  = 2'd3;
                    res_c.payload_length = r_job.len;
                    res_c.last           = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_job_valid <= i_job.valid;
            end
            if (done || !r_job_valid) begin
                r_step <= 2'd0;
            end else if (load) begin
                r_step <= r_step + 2'd1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_job.valid) begin
            r_job <= i_job;
        end
        if (load) begin
            r_res <= res_c;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

[rtl/core/debug_packet_receiver_unit.sv]
// Debug packet receiver, "$body#hh" line framing, top level.
// Depends on dpr_pkg, dpr_parse, dpr_buf and dpr_tx.
//
// Usage: the input channel (i_valid / o_ready) carries one item per
// transfer: a received line byte (i_action = 0) or a request to read the
// buffered byte at i_read_index (i_action = 1). The output channel
// (o_valid / i_ready) carries results: the reply characters '+', '-' and
// the two sequence id characters, the packet report on the last result of
// a good packet, and read data. Line bytes other than the last checksum
// digit cause no result.
// Throughput: one input transfer per cycle while o_ready is high. A result
// passes the reply job register (and, for a read, the buffer read register),
// then the output register. A good packet with a sequence id gives three
// results and holds o_ready low while they drain; all other items give at most
// one result and never stall the input on their own.
// The payload buffer is BUF_DEPTH bytes with one write port for body bytes
// and one registered read port for read transfers; it is not cleared, so
// reading a position not written since reset returns an arbitrary byte.
// Reset (synchronous, active low) returns the parser to hunting for '$'
// and empties the reply job and output registers. When the receiver holds
// i_ready low, the output register keeps its result, one job waits behind
// it, and o_ready drops until the job can move on.
module debug_packet_receiver_unit #(
    parameter int BUF_DEPTH = dpr_pkg::BUF_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_action,
    input  logic [7:0]                i_line_byte,
    input  logic [dpr_pkg::IDX_W-1:0] i_read_index,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_tx_valid,
    output logic [7:0]                o_tx_byte,
    output logic                      o_packet_ready,
    output logic [1:0]                o_payload_start,
    output logic [dpr_pkg::LEN_W-1:0] o_payload_length,
    output logic [7:0]                o_read_data,
    output logic                      o_last
);
    import dpr_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    rd_data;
    t_job          job;
    t_res          res;

    // An input transfer completes when valid meets ready.
    assign accept = i_valid && o_ready;

    dpr_parse #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_action   (i_action),
        .i_line_byte(i_line_byte),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_job      (job)
    );

    dpr_buf #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept && i_action),
        .i_rd_index(i_read_index),
        .o_rd_data (rd_data)
    );

    dpr_tx u_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job),
        .i_rd_data  (rd_data),
        .i_out_ready(i_ready),
        .o_in_ready (o_ready),
        .o_out_valid(o_valid),
        .o_res      (res)
    );

    assign o_tx_valid       = res.tx_valid;
    assign o_tx_byte        = res.tx_byte;
    assign o_packet_ready   = res.packet_ready;
    assign o_payload_start  = res.payload_start;
    assign o_payload_length = res.payload_length;
    assign o_read_data      = res.read_data;
    assign o_last           = res.last;

endmodule

[rtl/core/dpr_checker.sv]
// Port-level checks of the debug packet receiver output channel.
// Depends on assert_macros.svh; bound to debug_packet_receiver_unit below.
`include "assert_macros.svh"

module dpr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_ready,
    input logic       o_valid,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_byte,
    input logic       o_packet_ready,
    input logic [1:0] o_payload_start,
    input logic [7:0] o_read_data
);

    `ASSERT_IMPL(a_idle_byte_zero, i_clk, i_rst_n, o_valid && !o_tx_valid, o_tx_byte == 8'h00, "tx byte set without tx valid")
    `ASSERT_IMPL(a_ready_is_ack, i_clk, i_rst_n, o_valid && o_packet_ready, o_tx_valid, "packet report without reply byte")
    `ASSERT_IMPL(a_read_no_tx, i_clk, i_rst_n, o_valid && o_read_data != 8'h00, !o_tx_valid && !o_packet_ready, "read result mixed with reply")
    `ASSERT_IMPL(a_seq_start, i_clk, i_rst_n, o_valid && o_payload_start != 2'd0, o_packet_ready && o_payload_start == 2'd3, "payload start without report")
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_tx_byte), "stalled result changed")

endmodule

bind debug_packet_receiver_unit dpr_checker u_dpr_checker (.*);

[sim/debug_packet_receiver_unit_tb.sv]
// Testbench for the debug packet receiver: directed frames, an overflow and a full-size packet,
// a receiver hold-off, then random framed traffic, scored against an in-bench predictor and typed replies.
// Depends on dpr_pkg and debug_packet_receiver_unit.
module debug_packet_receiver_unit_tb;

    import dpr_pkg::*;

    localparam int DEPTH        = BUF_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 430;
    localparam int IDLE_PCT     = 11;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    localparam bit ACT_RX   = 1'b0;
    localparam bit ACT_READ = 1'b1;
    localparam logic [7:0] NOT_HEX = 8'hFF;

    localparam t_res NO_CHECK       = '0;
    localparam t_res WANT_ACK_EMPTY = '{tx_valid: 1'b1, tx_byte: CH_PLUS, packet_ready: 1'b1,
                                        last: 1'b1, default: '0};
    localparam t_res WANT_NACK      = '{tx_valid: 1'b1, tx_byte: CH_MINUS, last: 1'b1,
                                        default: '0};
    localparam t_res WANT_COLON     = '{read_data: CH_COLON, last: 1'b1, default: '0};
    localparam t_res WANT_ZERO_BYTE = '{last: 1'b1, default: '0};

    typedef struct {
        bit         act;
        logic [7:0] c;
        logic [9:0] idx;
        bit         typed;
        t_res       want;
    } t_script_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic             i_action;
    logic [7:0]       i_line_byte;
    logic [IDX_W-1:0] i_read_index;
    logic             o_valid;
    logic             i_ready;
    logic             o_tx_valid;
    logic [7:0]       o_tx_byte;
    logic             o_packet_ready;
    logic [1:0]       o_payload_start;
    logic [LEN_W-1:0] o_payload_length;
    logic [7:0]       o_read_data;
    logic             o_last;

    // Predictor state: a shadow of the frame parser and of the payload store.
    logic [1:0] fr_phase;
    logic [7:0] fr_sum;
    logic [7:0] fr_high;
    int         fr_count;
    logic [7:0] fr_store [DEPTH];
    int         fr_top;          // entries below this index have been written
    t_res       pred_out [3];

    t_res pending_replies [$];
    t_res seen_reply;

    bit idle_on;
    int hold_epoch;
    int n_errors;
    int n_items;
    int n_live;
    int n_checked;
    int n_reported;
    int n_rejects;
    int n_readbacks;

    debug_packet_receiver_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_line_byte      (i_line_byte),
        .i_read_index     (i_read_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_tx_valid       (o_tx_valid),
        .o_tx_byte        (o_tx_byte),
        .o_packet_ready   (o_packet_ready),
        .o_payload_start  (o_payload_start),
        .o_payload_length (o_payload_length),
        .o_read_data      (o_read_data),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_res mk_res(input logic txv, input logic [7:0] txb, input logic rdy,
                                    input logic [1:0] start, input logic [9:0] len,
                                    input logic [7:0] rd, input logic lst);
        t_res r;
        r.tx_valid       = txv;
        r.tx_byte        = txb;
        r.packet_ready   = rdy;
        r.payload_start  = start;
        r.payload_length = len;
        r.read_data      = rd;
        r.last           = lst;
        return r;
    endfunction

    // Checksum digit value; anything that is not a hex digit counts as all ones.
    function automatic logic [7:0] nibble_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
        if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 8'd10;
        if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 8'd10;
        return NOT_HEX;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return CH_ZERO + 8'(n);
        return (upper ? CH_UA : CH_LA) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_DOLLAR || b == CH_HASH);
        return b;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (nibble_of(b) != NOT_HEX);
        return b;
    endfunction

    // Advances the shadow parser by one accepted item and returns how many replies it causes.
    function automatic int frame_predict(input bit act, input logic [7:0] c,
                                         input logic [9:0] idx);
        logic [7:0] sent;
        if (act == ACT_READ) begin
            pred_out[0] = mk_res(1'b0, 8'h00, 1'b0, 2'd0, 10'd0,
                                 (int'(idx) < DEPTH) ? fr_store[idx] : 8'h00, 1'b1);
            return 1;
        end
        case (fr_phase)
            PH_HUNT: begin
                if (c == CH_DOLLAR) begin
                    fr_phase = PH_BODY;
                    fr_sum   = 8'h00;
                    fr_count = 0;
                end
            end
            PH_BODY: begin
                if (c == CH_DOLLAR) begin
                    fr_sum   = 8'h00;
                    fr_count = 0;
                end else if (c == CH_HASH) begin
                    fr_phase = PH_HIGH;
                end else begin
                    fr_sum = fr_sum + c;
                    if (fr_count < DEPTH) begin
                        fr_store[fr_count] = c;
                        if (fr_count >= fr_top) fr_top = fr_count + 1;
                    end
                    fr_count++;
                    // A body of DEPTH - 1 bytes is dropped without any reply.
                    if (fr_count >= DEPTH - 1) fr_phase = PH_HUNT;
                end
            end
            PH_HIGH: begin
                fr_high  = nibble_of(c) << 4;
                fr_phase = PH_LOW;
            end
            default: begin
                sent     = fr_high + nibble_of(c);
                fr_phase = PH_HUNT;
                if (sent != fr_sum) begin
                    pred_out[0] = mk_res(1'b1, CH_MINUS, 1'b0, 2'd0, 10'd0, 8'h00, 1'b1);
                    return 1;
                end
                if (fr_count >= 3 && fr_store[2] == CH_COLON) begin
                    pred_out[0] = mk_res(1'b1, CH_PLUS, 1'b0, 2'd0, 10'd0, 8'h00, 1'b0);
                    pred_out[1] = mk_res(1'b1, fr_store[0], 1'b0, 2'd0, 10'd0, 8'h00, 1'b0);
                    pred_out[2] = mk_res(1'b1, fr_store[1], 1'b1, 2'd3, 10'(fr_count), 8'h00,
                                         1'b1);
                    return 3;
                end
                pred_out[0] = mk_res(1'b1, CH_PLUS, 1'b1, 2'd0, 10'(fr_count), 8'h00, 1'b1);
                return 1;
            end
        endcase
        return 0;
    endfunction

    // Offers one item, waits for the transfer, then books the replies it must cause.
    // A typed row books its written-out reply in place of the predicted one.
    task automatic push_item(input bit act, input logic [7:0] c, input logic [9:0] idx,
                             input bit typed, input t_res want);
        int n;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_line_byte  <= c;
        i_read_index <= idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_items++;
        if (act == ACT_READ || fr_phase != PH_HUNT || c == CH_DOLLAR) n_live++;
        n = frame_predict(act, c, idx);
        if (typed) begin
            pending_replies.push_back(want);
        end else begin
            for (int k = 0; k < n; k++) pending_replies.push_back(pred_out[k]);
        end
    endtask

    task automatic push_line(input logic [7:0] c);
        push_item(ACT_RX, c, 10'($urandom_range(0, 1023)), 1'b0, NO_CHECK);
    endtask

    task automatic push_read(input int idx);
        push_item(ACT_READ, 8'($urandom_range(0, 255)), 10'(idx), 1'b0, NO_CHECK);
    endtask

    // Sends a whole frame. A restart sends a few abandoned body bytes and a second '$' first;
    // a bad checksum either flips bits of the low digit or replaces the high digit.
    task automatic send_packet(input int len, input bit seq, input bit bad_sum,
                               input bit restart);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] hi_c;
        logic [7:0] lo_c;
        logic [3:0] flip;
        sum = 8'h00;
        push_line(CH_DOLLAR);
        if (restart) begin
            repeat ($urandom_range(1, 3)) push_line(body_byte());
            push_line(CH_DOLLAR);
        end
        for (int i = 0; i < len; i++) begin
            b   = (seq && i == 2) ? CH_COLON : body_byte();
            sum = sum + b;
            push_line(b);
        end
        push_line(CH_HASH);
        hi_c = hex_char(sum[7:4], $urandom_range(0, 1));
        lo_c = hex_char(sum[3:0], $urandom_range(0, 1));
        if (bad_sum) begin
            if ($urandom_range(0, 1)) begin
                flip = 4'($urandom_range(1, 15));
                lo_c = hex_char(sum[3:0] ^ flip, $urandom_range(0, 1));
            end else begin
                hi_c = non_hex_byte();
            end
        end
        push_line(hi_c);
        push_line(lo_c);
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    // Reply scoreboard: every result transfer is matched against the oldest booked reply.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result: tx_valid %0d tx_byte %0d read_data %0d last %0d",
                       o_tx_valid, o_tx_byte, o_read_data, o_last);
                n_errors++;
            end else begin
                seen_reply = pending_replies.pop_front();
                n_checked++;
                check_field("tx_valid", seen_reply.tx_valid, o_tx_valid);
                check_field("tx_byte", seen_reply.tx_byte, o_tx_byte);
                check_field("packet_ready", seen_reply.packet_ready, o_packet_ready);
                check_field("payload_start", seen_reply.payload_start, o_payload_start);
                check_field("payload_length", seen_reply.payload_length, o_payload_length);
                check_field("read_data", seen_reply.read_data, o_read_data);
                check_field("last", seen_reply.last, o_last);
                if (seen_reply.packet_ready) n_reported++;
                if (seen_reply.tx_valid && seen_reply.tx_byte == CH_MINUS) n_rejects++;
                if (!seen_reply.tx_valid) n_readbacks++;
            end
        end
    end

    // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
    initial begin : rx_side
        int hold_left;
        int seen_epoch;
        hold_left  = 0;
        seen_epoch = 0;
        i_ready    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_epoch != seen_epoch) begin
                seen_epoch = hold_epoch;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        t_script_row script [$];
        int live_at_start;
        int pick;
        int len;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_action     = ACT_RX;
        i_line_byte  = 8'h00;
        i_read_index = '0;
        idle_on      = 1'b1;
        hold_epoch   = 0;
        n_errors     = 0;
        n_items      = 0;
        n_live       = 0;
        n_checked    = 0;
        n_reported   = 0;
        n_rejects    = 0;
        n_readbacks  = 0;
        fr_phase     = PH_HUNT;
        fr_sum       = 8'h00;
        fr_high      = 8'h00;
        fr_count     = 0;
        fr_top       = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        script = '{
            // Empty body with a zero checksum.
            '{ACT_RX,   CH_DOLLAR, 10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   CH_HASH,   10'd1023, 1'b0, NO_CHECK},
            '{ACT_RX,   CH_ZERO,   10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   CH_ZERO,   10'd1023, 1'b1, WANT_ACK_EMPTY},
            // An all-ones byte is thrown away by a restart; then a body with a sequence id
            // and a zero byte.
            '{ACT_RX,   CH_DOLLAR, 10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   8'hFF,     10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   CH_DOLLAR, 10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   "1",       10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   "2",       10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   CH_COLON,  10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   8'h00,     10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   CH_HASH,   10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   "9",       10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   "d",       10'd0,    1'b0, NO_CHECK},
            // Two-byte body: the colon left in the store must not count as a sequence id.
            '{ACT_RX,   CH_DOLLAR, 10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   "1",       10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   "2",       10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   CH_HASH,   10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   "6",       10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   "3",       10'd0,    1'b0, NO_CHECK},
            // Framing characters taken as checksum digits, which are not hex.
            '{ACT_RX,   CH_DOLLAR, 10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   CH_HASH,   10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   CH_DOLLAR, 10'd0,    1'b0, NO_CHECK},
            '{ACT_RX,   CH_HASH,   10'd0,    1'b1, WANT_NACK},
            '{ACT_READ, 8'hFF,     10'd2,    1'b1, WANT_COLON},
            '{ACT_READ, 8'h00,     10'd3,    1'b1, WANT_ZERO_BYTE}
        };
        foreach (script[i]) begin
            push_item(script[i].act, script[i].c, script[i].idx, script[i].typed,
                      script[i].want);
        end

        // A body of DEPTH - 1 bytes is dropped; the trailer after it arrives while hunting.
        push_line(CH_DOLLAR);
        repeat (DEPTH - 1) push_line(body_byte());
        push_line(CH_HASH);
        push_line(CH_ZERO);
        push_line(CH_ZERO);
        // Longest body that can still be reported, with a sequence id.
        send_packet(DEPTH - 2, 1'b1, 1'b0, 1'b0);
        push_read(DEPTH - 2);

        // Hold the result side off while reads keep coming, so the input backs up.
        hold_epoch++;
        repeat (16) push_read($urandom_range(0, fr_top - 1));

        live_at_start = n_live;
        while (n_live - live_at_start < RANDOM_ITEMS) begin
            idle_on = !(n_live - live_at_start >= 150 && n_live - live_at_start < 260);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                repeat ($urandom_range(0, 2)) push_line(body_byte());
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 60)
                                                   : $urandom_range(0, 8);
                send_packet(len, len >= 3 && $urandom_range(0, 1) == 1,
                            $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
            end else if (pick < 85) begin
                push_read($urandom_range(0, fr_top - 1));
            end else if (pick < 93) begin
                // Truncated frame; whatever follows restarts or continues it.
                push_line(CH_DOLLAR);
                repeat ($urandom_range(0, 4)) push_line(body_byte());
            end else begin
                repeat ($urandom_range(1, 4)) push_line(8'($urandom));
            end
        end
        idle_on = 1'b1;
        i_valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d random) incl. a dropped full-store body and a %0d-byte %s",
                 n_items, n_live - live_at_start, DEPTH - 2, "frame.");
        $display("Scored %0d results: %0d frames reported, %0d rejected, %0d buffer reads.",
                 n_checked, n_reported, n_rejects, n_readbacks);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
